FILE: rtl/core/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// Two-class priority queue package
// Shared widths, command and status codes, defaults and the result record.
// ----------------------------------------------------------------------------
package tcpq_pkg;

	// Fixed field widths of the channels.
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned PAYLOAD_W  = 8;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned TAG_OUT_W  = 16;
	localparam int unsigned WAIT_CNT_W = 6;
	localparam int unsigned URG_CNT_W  = 5;

	// Defaults for the top-level parameters.
	localparam int unsigned CLASS_DEPTH_DEF = 16;
	localparam int unsigned TAG_BITS_DEF    = 16;

	// Command codes. Any other code is treated as a serve.
	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ_NORMAL = 2'd0,
		CMD_ENQ_URGENT = 2'd1,
		CMD_SERVE      = 2'd2
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	// Result record handed from the queue control to the output pipeline.
	typedef struct packed {
		status_t               status;
		logic                  from_urgent;
		logic [WAIT_CNT_W-1:0] waiting_count;
		logic [URG_CNT_W-1:0]  urgent_count;
	} result_t;

endpackage

FILE: rtl/core/tcpq_if.sv
// ----------------------------------------------------------------------------
// Two-class priority queue channels
// Valid/ready channels for the request, the result and the tag setup.
// ----------------------------------------------------------------------------

// Request channel: one command per beat.
interface tcpq_req_if;
	logic                             valid;
	logic                             ready;
	logic [tcpq_pkg::CMD_W-1:0]       cmd;
	logic [tcpq_pkg::PAYLOAD_W-1:0]   payload;

	modport source (output valid, output cmd, output payload, input ready);
	modport sink (input valid, input cmd, input payload, output ready);
endinterface

// Result channel: one result per beat.
interface tcpq_rsp_if;
	logic                             valid;
	logic                             ready;
	tcpq_pkg::status_t                status;
	logic [tcpq_pkg::TAG_OUT_W-1:0]   served_tag;
	logic [tcpq_pkg::PAYLOAD_W-1:0]   served_payload;
	logic [tcpq_pkg::WAIT_CNT_W-1:0]  waiting_count;
	logic [tcpq_pkg::URG_CNT_W-1:0]   urgent_count;

	modport source (output valid, output status, output served_tag, output served_payload,
		output waiting_count, output urgent_count, input ready);
	modport sink (input valid, input status, input served_tag, input served_payload,
		input waiting_count, input urgent_count, output ready);
endinterface

// Configuration channel: writes the first tag.
interface tcpq_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tcpq_pkg::CFG_W-1:0]       first_tag;

	modport source (output valid, output first_tag, input ready);
	modport sink (input valid, input first_tag, output ready);
endinterface

FILE: rtl/core/tcpq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcpq_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// Two-class priority queue control
// Head, tail and fill counters of both classes, the tag counter and the
// decision for each accepted request.
// ----------------------------------------------------------------------------
module tcpq_ctrl #(
	parameter int unsigned CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF,
	parameter int unsigned TAG_BITS    = tcpq_pkg::TAG_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Accepted request
	input  logic                                 acc,
	input  logic [tcpq_pkg::CMD_W-1:0]           cmd,
	input  logic [tcpq_pkg::PAYLOAD_W-1:0]       payload,
	// Tag setup
	input  logic                                 cfg_we,
	input  logic [tcpq_pkg::CFG_W-1:0]           cfg_first_tag,
	// Store ports
	output logic                                 u_we,
	output logic                                 n_we,
	output logic [$clog2(CLASS_DEPTH)-1:0]       u_waddr,
	output logic [$clog2(CLASS_DEPTH)-1:0]       n_waddr,
	output logic [TAG_BITS+tcpq_pkg::PAYLOAD_W-1:0] wdata,
	output logic                                 u_re,
	output logic                                 n_re,
	output logic [$clog2(CLASS_DEPTH)-1:0]       u_raddr,
	output logic [$clog2(CLASS_DEPTH)-1:0]       n_raddr,
	// Result of the accepted request
	output tcpq_pkg::result_t                    res
);

	localparam int unsigned AW = $clog2(CLASS_DEPTH);
	localparam int unsigned CW = $clog2(CLASS_DEPTH + 1);
	localparam logic [AW-1:0] LAST_POS = AW'(CLASS_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CLASS_DEPTH);

	logic [AW-1:0]       u_head_q, u_tail_q, n_head_q, n_tail_q;
	logic [CW-1:0]       u_fill_q, n_fill_q, u_fill_d, n_fill_d;
	logic [TAG_BITS-1:0] next_tag_q;
	logic                is_serve, is_urgent;
	logic                push_u, push_n, pop_u, pop_n;
	logic                u_empty, n_empty, u_full, n_full;
	logic [CW:0]         total_d;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == LAST_POS) ? '0 : p + 1'b1;
	endfunction

	// Command decode; the unused code serves.
	always_comb begin
		case (cmd)
			tcpq_pkg::CMD_ENQ_NORMAL: begin
				is_serve  = 1'b0;
				is_urgent = 1'b0;
			end
			tcpq_pkg::CMD_ENQ_URGENT: begin
				is_serve  = 1'b0;
				is_urgent = 1'b1;
			end
			default: begin
				is_serve  = 1'b1;
				is_urgent = 1'b0;
			end
		endcase
	end

	// Per-class push and pop decisions.
	assign u_empty = (u_fill_q == '0);
	assign n_empty = (n_fill_q == '0);
	assign u_full  = (u_fill_q == FULL_CNT);
	assign n_full  = (n_fill_q == FULL_CNT);
	assign push_u  = acc && !is_serve && is_urgent && !u_full;
	assign push_n  = acc && !is_serve && !is_urgent && !n_full;
	assign pop_u   = acc && is_serve && !u_empty;
	assign pop_n   = acc && is_serve && u_empty && !n_empty;

	// Fill levels after this request.
	always_comb begin
		u_fill_d = u_fill_q;
		n_fill_d = n_fill_q;
		if (push_u) begin
			u_fill_d = u_fill_q + 1'b1;
		end
		if (pop_u) begin
			u_fill_d = u_fill_q - 1'b1;
		end
		if (push_n) begin
			n_fill_d = n_fill_q + 1'b1;
		end
		if (pop_n) begin
			n_fill_d = n_fill_q - 1'b1;
		end
		total_d = {1'b0, u_fill_d} + {1'b0, n_fill_d};
	end

	// Result record.
	always_comb begin
		if (is_serve) begin
			res.status = (u_empty && n_empty) ? tcpq_pkg::ST_EMPTY : tcpq_pkg::ST_SERVED;
		end else if (is_urgent ? u_full : n_full) begin
			res.status = tcpq_pkg::ST_DROPPED;
		end else begin
			res.status = tcpq_pkg::ST_ENQUEUED;
		end
		res.from_urgent   = !u_empty;
		res.waiting_count = tcpq_pkg::WAIT_CNT_W'(total_d);
		res.urgent_count  = tcpq_pkg::URG_CNT_W'(u_fill_d);
	end

	// Store ports: write at the tail, read at the head.
	assign u_we    = push_u;
	assign n_we    = push_n;
	assign u_waddr = u_tail_q;
	assign n_waddr = n_tail_q;
	assign wdata   = {next_tag_q, payload};
	assign u_re    = pop_u;
	assign n_re    = pop_n;
	assign u_raddr = u_head_q;
	assign n_raddr = n_head_q;

	// Counters and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_head_q   <= '0;
			u_tail_q   <= '0;
			n_head_q   <= '0;
			n_tail_q   <= '0;
			u_fill_q   <= '0;
			n_fill_q   <= '0;
			next_tag_q <= '0;
		end else begin
			u_fill_q <= u_fill_d;
			n_fill_q <= n_fill_d;
			if (push_u) begin
				u_tail_q <= ptr_inc(u_tail_q);
			end
			if (pop_u) begin
				u_head_q <= ptr_inc(u_head_q);
			end
			if (push_n) begin
				n_tail_q <= ptr_inc(n_tail_q);
			end
			if (pop_n) begin
				n_head_q <= ptr_inc(n_head_q);
			end
			if (cfg_we) begin
				next_tag_q <= TAG_BITS'(cfg_first_tag);
			end else if (push_u || push_n) begin
				next_tag_q <= next_tag_q + 1'b1;
			end
		end
	end

	// Tail position implied by head and fill, for checking.
	logic [AW:0] u_sum, n_sum;
	logic [AW:0] u_tail_chk, n_tail_chk;

	always_comb begin
		u_sum = {1'b0, u_head_q} + (AW+1)'(u_fill_q);
		n_sum = {1'b0, n_head_q} + (AW+1)'(n_fill_q);
		u_tail_chk = (u_sum >= (AW+1)'(CLASS_DEPTH)) ? u_sum - (AW+1)'(CLASS_DEPTH) : u_sum;
		n_tail_chk = (n_sum >= (AW+1)'(CLASS_DEPTH)) ? n_sum - (AW+1)'(CLASS_DEPTH) : n_sum;
	end

	// The fill levels never pass the class depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(u_fill_q <= FULL_CNT) && (n_fill_q <= FULL_CNT))
		else $error("class fill level above depth");

	// The tail always sits fill entries past the head.
	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		(u_tail_chk == {1'b0, u_tail_q}) && (n_tail_chk == {1'b0, n_tail_q}))
		else $error("tail pointer out of step with head and fill");

	// A stored entry consumes exactly one tag.
	a_tag_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push_u || push_n) && !cfg_we |=> next_tag_q == $past(next_tag_q) + 1'b1)
		else $error("tag counter did not advance on enqueue");

	// At most one store is touched per request.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({push_u, push_n, pop_u, pop_n}))
		else $error("more than one store access in a cycle");

endmodule

FILE: rtl/core/two_class_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Two-class priority queue
// Urgent and normal circular stores with sequence tags; a serve takes the
// oldest urgent entry, else the oldest normal entry.
//
//   Channel | Dir  | Beat carries
//   --------+------+----------------------------------------------------------
//   req     | in   | cmd, payload
//   rsp     | out  | status, served_tag, served_payload, waiting_count,
//           |      | urgent_count
//   cfg     | in   | first_tag (loads the tag counter)
//
// One request per cycle is taken while the output does not stall; its result
// goes through the counter update with the store read, then the result register,
// from which it can be taken.
// The rate is set by the counter update and the store read.
// Reset clears the counters and sets the tag counter to zero; store contents
// are not cleared. A stalled result holds in the result register while one
// more request waits in the read stage; then req.ready drops.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top #(
	parameter int unsigned CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF,
	parameter int unsigned TAG_BITS    = tcpq_pkg::TAG_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tcpq_req_if.sink     req,
	tcpq_rsp_if.source   rsp,
	tcpq_cfg_if.sink     cfg
);

	localparam int unsigned AW = $clog2(CLASS_DEPTH);
	localparam int unsigned EW = TAG_BITS + tcpq_pkg::PAYLOAD_W;

	logic          acc;
	logic          u_we, n_we, u_re, n_re;
	logic [AW-1:0] u_waddr, n_waddr, u_raddr, n_raddr;
	logic [EW-1:0] wdata, u_rdata, n_rdata, sel_rdata;
	tcpq_pkg::result_t res, res_s1;
	logic          valid_s1, valid_s2, adv_s1;

	// Handshakes.
	assign cfg.ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign acc       = req.valid && req.ready;

	// Queue control.
	tcpq_ctrl #(
		.CLASS_DEPTH(CLASS_DEPTH),
		.TAG_BITS   (TAG_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.cmd          (req.cmd),
		.payload      (req.payload),
		.cfg_we       (cfg.valid),
		.cfg_first_tag(cfg.first_tag),
		.u_we         (u_we),
		.n_we         (n_we),
		.u_waddr      (u_waddr),
		.n_waddr      (n_waddr),
		.wdata        (wdata),
		.u_re         (u_re),
		.n_re         (n_re),
		.u_raddr      (u_raddr),
		.n_raddr      (n_raddr),
		.res          (res)
	);

	// Urgent entry store.
	tcpq_ram #(
		.WIDTH(EW),
		.DEPTH(CLASS_DEPTH)
	) u_urgent_ram (
		.clk  (clk),
		.we   (u_we),
		.waddr(u_waddr),
		.wdata(wdata),
		.re   (u_re),
		.raddr(u_raddr),
		.rdata(u_rdata)
	);

	// Normal entry store.
	tcpq_ram #(
		.WIDTH(EW),
		.DEPTH(CLASS_DEPTH)
	) u_normal_ram (
		.clk  (clk),
		.we   (n_we),
		.waddr(n_waddr),
		.wdata(wdata),
		.re   (n_re),
		.raddr(n_raddr),
		.rdata(n_rdata)
	);

	// Read stage: holds the result record while the store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	assign sel_rdata = res_s1.from_urgent ? u_rdata : n_rdata;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp.status        <= res_s1.status;
			rsp.waiting_count <= res_s1.waiting_count;
			rsp.urgent_count  <= res_s1.urgent_count;
			if (res_s1.status == tcpq_pkg::ST_SERVED) begin
				rsp.served_tag     <= tcpq_pkg::TAG_OUT_W'(sel_rdata[EW-1:tcpq_pkg::PAYLOAD_W]);
				rsp.served_payload <= sel_rdata[tcpq_pkg::PAYLOAD_W-1:0];
			end else begin
				rsp.served_tag     <= '0;
				rsp.served_payload <= '0;
			end
		end
	end

	assign rsp.valid = valid_s2;

	// A result never leaves the read stage into an occupied, stalled output.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp.ready |-> !adv_s1)
		else $error("result register overwritten while stalled");

	// With both stages full and the output stalled, no request is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp.ready |-> !acc)
		else $error("request accepted with the pipeline full");

	// A store read only comes with an accepted serve.
	a_read_on_serve: assert property (@(posedge clk) disable iff (!arst_n)
		(u_re || n_re) |-> acc && (res.status == tcpq_pkg::ST_SERVED))
		else $error("store read without a serve");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Two-class priority queue testbench
// Drives commands and tag setups into the queue and keeps its own copy of the
// urgent and normal stores. Every result beat is compared field by field with
// the oldest outcome still owed. The run covers empty serves, full classes,
// tag wrap and several first-tag settings under varying back-pressure.
// ----------------------------------------------------------------------------
module tb;
	import tcpq_pkg::*;

	localparam int DEPTH       = CLASS_DEPTH_DEF;
	localparam int TAG_BITS    = TAG_BITS_DEF;
	localparam int HEAD_W      = $clog2(DEPTH);
	localparam int NORMAL      = 0;
	localparam int URGENT      = 1;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 290;

	// The spare command code decodes as a serve.
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [PAYLOAD_W-1:0] payload;
	} request_t;

	typedef struct packed {
		status_t               status;
		logic [TAG_OUT_W-1:0]  tag;
		logic [PAYLOAD_W-1:0]  payload;
		logic [WAIT_CNT_W-1:0] waiting;
		logic [URG_CNT_W-1:0]  urgent;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	tcpq_req_if req();
	tcpq_rsp_if rsp();
	tcpq_cfg_if cfg();

	two_class_priority_queue_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #4 clk = ~clk;

	request_t cmd_backlog[$];
	outcome_t outcomes_due[$];
	int       mismatches    = 0;
	int       quiet_cycles  = 0;
	int       send_idle_pct = 8;
	int       recv_idle_pct = 77;

	// Shadow copy of both class stores; index 0 is normal, 1 is urgent.
	logic [TAG_BITS-1:0]  held_tag  [2][DEPTH];
	logic [PAYLOAD_W-1:0] held_pay  [2][DEPTH];
	logic [HEAD_W-1:0]    class_head[2] = '{default: '0};
	logic [HEAD_W:0]      class_fill[2] = '{default: '0};
	logic [TAG_BITS-1:0]  tag_next      = '0;

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one command to the shadow stores and returns the result it owes.
	function automatic outcome_t queue_outcome(logic [CMD_W-1:0] cmd,
			logic [PAYLOAD_W-1:0] payload);
		outcome_t          o;
		int                c;
		logic [HEAD_W-1:0] slot;
		o = '0;
		if (cmd[1]) begin
			if (class_fill[URGENT] != 0) c = URGENT;
			else if (class_fill[NORMAL] != 0) c = NORMAL;
			else c = -1;
			if (c < 0) begin
				o.status = ST_EMPTY;
			end else begin
				o.status          = ST_SERVED;
				o.tag             = held_tag[c][class_head[c]];
				o.payload         = held_pay[c][class_head[c]];
				class_head[c]     = class_head[c] + 1'b1;
				class_fill[c]     = class_fill[c] - 1'b1;
			end
		end else begin
			c = (cmd == CMD_ENQ_URGENT) ? URGENT : NORMAL;
			if (class_fill[c] == (HEAD_W+1)'(DEPTH)) begin
				o.status = ST_DROPPED;
			end else begin
				slot              = class_head[c] + class_fill[c][HEAD_W-1:0];
				held_tag[c][slot] = tag_next;
				held_pay[c][slot] = payload;
				class_fill[c]     = class_fill[c] + 1'b1;
				tag_next          = tag_next + 1'b1;
				o.status          = ST_ENQUEUED;
			end
		end
		o.waiting = class_fill[NORMAL] + class_fill[URGENT];
		o.urgent  = class_fill[URGENT];
		return o;
	endfunction

	// Request driver: presents the backlog head and predicts on each accepted beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				outcomes_due.push_back(queue_outcome(req.cmd, req.payload));
				void'(cmd_backlog.pop_front());
			end
			if (!req.valid || req.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req.valid   <= 1'b1;
					req.cmd     <= cmd_backlog[0].cmd;
					req.payload <= cmd_backlog[0].payload;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted beat against the oldest owed outcome.
	always @(posedge clk) begin : check_beat
		outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (outcomes_due.size() == 0) begin
				report($sformatf("result beat with status %0d but no outcome owed",
					rsp.status));
			end else begin
				want = outcomes_due.pop_front();
				if (rsp.status !== want.status)
					report($sformatf("status got %0d, expected %0d", rsp.status,
						want.status));
				if (rsp.served_tag !== want.tag)
					report($sformatf("served_tag got %h, expected %h", rsp.served_tag,
						want.tag));
				if (rsp.served_payload !== want.payload)
					report($sformatf("served_payload got %h, expected %h",
						rsp.served_payload, want.payload));
				if (rsp.waiting_count !== want.waiting)
					report($sformatf("waiting_count got %0d, expected %0d",
						rsp.waiting_count, want.waiting));
				if (rsp.urgent_count !== want.urgent)
					report($sformatf("urgent_count got %0d, expected %0d",
						rsp.urgent_count, want.urgent));
			end
		end
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: ends the run after too many cycles without any beat.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic add_item(logic [CMD_W-1:0] cmd, logic [PAYLOAD_W-1:0] payload);
		request_t r;
		r.cmd     = cmd;
		r.payload = payload;
		cmd_backlog.push_back(r);
	endtask

	// Waits until every command is taken and every owed result has come back.
	task automatic settle();
		while (cmd_backlog.size() != 0 || outcomes_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes the first tag; the shadow tag counter follows on the accepted beat.
	task automatic load_first_tag(logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg.valid     <= 1'b1;
		cfg.first_tag <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		tag_next  = value;
		cfg.valid <= 1'b0;
	endtask

	// Random traffic in runs: filling, draining, balanced and flooding one class.
	task automatic plan_traffic(int count);
		int               left;
		int               run;
		int               enq_pct;
		int               urg_pct;
		logic [CMD_W-1:0] cmd;
		left = count;
		while (left > 0) begin
			run = $urandom_range(40, 4);
			if (run > left) run = left;
			urg_pct = $urandom_range(90, 10);
			case ($urandom_range(4))
				0: begin
					enq_pct = 80;
				end
				1: begin
					enq_pct = 20;
				end
				2: begin
					enq_pct = 50;
				end
				3: begin
					enq_pct = 90;
					urg_pct = 95;
				end
				default: begin
					enq_pct = 90;
					urg_pct = 5;
				end
			endcase
			repeat (run) begin
				if ($urandom_range(99) < enq_pct)
					cmd = ($urandom_range(99) < urg_pct) ? CMD_ENQ_URGENT : CMD_ENQ_NORMAL;
				else
					cmd = ($urandom_range(9) == 0) ? CMD_SPARE : CMD_SERVE;
				add_item(cmd, 8'($urandom_range(255)));
			end
			left -= run;
		end
	endtask

	initial begin
		logic [CFG_W-1:0] phase_tag[6];
		phase_tag = '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'hFFFE};
		phase_tag[2] = 16'($urandom_range(65535));
		phase_tag[4] = 16'($urandom_range(65535));

		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.cmd       = CMD_ENQ_NORMAL;
		req.payload   = '0;
		rsp.ready     = 1'b0;
		cfg.valid     = 1'b0;
		cfg.first_tag = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty serves with both serve codes, then both classes and priority order.
		add_item(CMD_SERVE, 8'h00);
		add_item(CMD_SPARE, 8'hFF);
		add_item(CMD_ENQ_NORMAL, 8'h00);
		add_item(CMD_ENQ_NORMAL, 8'hFF);
		add_item(CMD_ENQ_URGENT, 8'hA5);
		add_item(CMD_SERVE, 8'h00);
		add_item(CMD_SPARE, 8'h00);
		add_item(CMD_SERVE, 8'h00);
		settle();

		// Fill the urgent class past its depth with tags wrapping through zero.
		load_first_tag(16'hFFF8);
		for (int i = 0; i <= DEPTH; i++)
			add_item(CMD_ENQ_URGENT, 8'(i * 17));
		settle();

		// Random phases: two back-pressure mixes, then no idling at all.
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 8;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			load_first_tag(phase_tag[p]);
			plan_traffic(PHASE_ITEMS);
			settle();
		end

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
